// ----- rtl/core/slid_pkg.sv -----
// ----------------------------------------------------------------------------
// slid_pkg
// Shared types and constants for the sorted list insert and dedupe core.
// ----------------------------------------------------------------------------
package slid_pkg;

  localparam int DEF_CAPACITY = 16;

  localparam int VALUE_W  = 32;
  localparam int FUNC_W   = 2;
  localparam int POS_W    = 5;
  localparam int CNT_W    = 5;
  localparam int STATUS_W = 2;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT    = 2'd0,
    FUNC_DEDUPE    = 2'd1,
    FUNC_READ_ASC  = 2'd2,
    FUNC_READ_DESC = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_PUT,
    S_DEDUP,
    S_READ,
    S_DONE
  } state_t;

endpackage

// ----- rtl/core/slid_ram.sv -----
// ----------------------------------------------------------------------------
// slid_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module slid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/sorted_list_insert_dedupe_core.sv -----
// ----------------------------------------------------------------------------
// sorted_list_insert_dedupe_core
// Bounded list of signed 32-bit values kept in ascending order in one RAM.
// ----------------------------------------------------------------------------
// The list lives in a CAPACITY-entry RAM with one write port and a registered
// read port; each walk through it steps one entry per cycle, a read-out only
// while the sink is ready. An insert reads from the top entry down and moves
// each entry that is not smaller than the new value up by one. Deduplicate
// reads every entry once and writes the kept ones back in place. A read-out
// gives one beat per cycle while the sink is ready, after the first RAM read.
// A full insert, an empty read-out and a deduplicate of an empty list skip the
// walk and answer with a single result beat. The next input beat is taken once
// the current operation has handed its last result to the output register.
module sorted_list_insert_dedupe_core
  import slid_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [VALUE_W-1:0]    s_axis_tdata,   // value[31:0]
  input  logic [FUNC_W-1:0]     s_axis_tuser,   // func[1:0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // item_value[31:0], position[36:32],
                                                // count[41:37], zero[47:42]
  output logic [STATUS_W-1:0]   m_axis_tuser,   // status[1:0]
  output logic                  m_axis_tlast
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  state_t              state, state_next;
  logic [CW-1:0]       count, count_next;
  logic [VALUE_W-1:0]  val, val_next;
  logic [VALUE_W-1:0]  last_val, last_val_next;
  logic [AW-1:0]       idx, idx_next;
  logic [AW-1:0]       ins_pos, ins_pos_next;
  logic [AW-1:0]       rd_addr, rd_addr_next;
  logic [CW-1:0]       kept, kept_next;
  logic                dir, dir_next;
  status_t             res_status, res_status_next;

  logic [VALUE_W-1:0]  out_item, out_item_next;
  logic [POS_W-1:0]    out_pos, out_pos_next;
  logic [CNT_W-1:0]    out_count, out_count_next;
  status_t             out_status, out_status_next;
  logic                out_last, out_last_next;
  logic                out_valid, out_valid_next;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [VALUE_W-1:0]  ram_wdata, ram_rdata;

  logic                accept, out_free, top_hit, ge, keep;
  logic [AW-1:0]       top_addr;
  func_t               in_func;

  slid_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_func       = func_t'(s_axis_tuser);
  assign out_free      = !out_valid || m_axis_tready;
  assign top_addr      = AW'(count - CW'(1));
  assign top_hit       = (idx == top_addr);
  assign ge            = !($signed(ram_rdata) < $signed(val));
  assign keep          = (idx == '0) || (ram_rdata != last_val);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W - VALUE_W - POS_W - CNT_W){1'b0}},
                          out_count, out_pos, out_item};
  assign m_axis_tuser  = out_status;
  assign m_axis_tlast  = out_last;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (in_func)
            FUNC_INSERT: begin
              if (count >= CW'(CAPACITY)) begin
                state_next = S_DONE;
              end else if (count == '0) begin
                state_next = S_PUT;
              end else begin
                state_next = S_INS;
              end
            end
            FUNC_DEDUPE: state_next = (count == '0) ? S_DONE : S_DEDUP;
            FUNC_READ_ASC,
            FUNC_READ_DESC: state_next = (count == '0) ? S_DONE : S_READ;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_INS: begin
        if (!ge || idx == '0) begin
          state_next = S_PUT;
        end
      end
      S_PUT: state_next = S_DONE;
      S_DEDUP: begin
        if (top_hit) begin
          state_next = S_DONE;
        end
      end
      S_READ: begin
        if (out_free && top_hit) begin
          state_next = S_IDLE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    count_next      = count;
    val_next        = val;
    last_val_next   = last_val;
    idx_next        = idx;
    ins_pos_next    = ins_pos;
    rd_addr_next    = rd_addr;
    kept_next       = kept;
    dir_next        = dir;
    res_status_next = res_status;
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = '0;
    ram_re          = 1'b0;
    ram_raddr       = '0;
    out_valid_next  = out_valid && !m_axis_tready;
    out_item_next   = out_item;
    out_pos_next    = out_pos;
    out_count_next  = out_count;
    out_status_next = out_status;
    out_last_next   = out_last;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_status_next = STATUS_OK;
          idx_next        = '0;
          unique case (in_func)
            FUNC_INSERT: begin
              val_next     = s_axis_tdata;
              ins_pos_next = '0;
              if (count >= CW'(CAPACITY)) begin
                res_status_next = STATUS_FULL;
              end else if (count != '0) begin
                ram_re    = 1'b1;
                ram_raddr = top_addr;
                idx_next  = top_addr;
              end
            end
            FUNC_DEDUPE: begin
              kept_next = '0;
              ram_re    = 1'b1;
              ram_raddr = '0;
            end
            FUNC_READ_ASC,
            FUNC_READ_DESC: begin
              dir_next = (in_func == FUNC_READ_DESC);
              if (count == '0) begin
                res_status_next = STATUS_EMPTY;
              end else begin
                ram_re       = 1'b1;
                ram_raddr    = (in_func == FUNC_READ_DESC) ? top_addr : '0;
                rd_addr_next = ram_raddr;
              end
            end
            default: ;
          endcase
        end
      end
      S_INS: begin
        if (ge) begin
          ram_we    = 1'b1;
          ram_waddr = idx + AW'(1);
          ram_wdata = ram_rdata;
          if (idx == '0) begin
            ins_pos_next = '0;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx - AW'(1);
            idx_next  = idx - AW'(1);
          end
        end else begin
          ins_pos_next = idx + AW'(1);
        end
      end
      S_PUT: begin
        ram_we     = 1'b1;
        ram_waddr  = ins_pos;
        ram_wdata  = val;
        count_next = count + CW'(1);
      end
      S_DEDUP: begin
        if (keep) begin
          ram_we        = 1'b1;
          ram_waddr     = AW'(kept);
          ram_wdata     = ram_rdata;
          kept_next     = kept + CW'(1);
          last_val_next = ram_rdata;
        end
        if (top_hit) begin
          count_next = keep ? (kept + CW'(1)) : kept;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx + AW'(1);
          idx_next  = idx + AW'(1);
        end
      end
      S_READ: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_item_next   = ram_rdata;
          out_pos_next    = POS_W'(idx);
          out_count_next  = CNT_W'(count);
          out_status_next = STATUS_OK;
          out_last_next   = top_hit;
          if (!top_hit) begin
            ram_re       = 1'b1;
            ram_raddr    = dir ? (rd_addr - AW'(1)) : (rd_addr + AW'(1));
            rd_addr_next = ram_raddr;
            idx_next     = idx + AW'(1);
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_item_next   = '0;
          out_pos_next    = '0;
          out_count_next  = CNT_W'(count);
          out_status_next = res_status;
          out_last_next   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    val        <= val_next;
    last_val   <= last_val_next;
    idx        <= idx_next;
    ins_pos    <= ins_pos_next;
    rd_addr    <= rd_addr_next;
    kept       <= kept_next;
    dir        <= dir_next;
    res_status <= res_status_next;
    out_item   <= out_item_next;
    out_pos    <= out_pos_next;
    out_count  <= out_count_next;
    out_status <= out_status_next;
    out_last   <= out_last_next;
  end

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Checks the sorted list core on insert, dedupe and both read-outs.
// ----------------------------------------------------------------------------
// Commands go in on the slave stream and every result beat is compared with a
// list kept in the bench that is updated on each accepted command. Directed
// tests cover the empty list, extreme values, equal values and the full list.
// Random tests then mix all four operations over a value pool that is rich in
// duplicates, first with both streams always ready and then with random
// stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top
  import slid_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP        = DEF_CAPACITY;
  localparam int IDLE_PCT   = 35;
  localparam int STALL_LIM  = 5000;
  localparam int TAIL_WAIT  = 2 * CAP + 16;
  localparam int POS_LO     = VALUE_W;
  localparam int CNT_LO     = VALUE_W + POS_W;

  typedef struct {
    logic [VALUE_W-1:0]  item_value;
    logic [POS_W-1:0]    position;
    logic [CNT_W-1:0]    count;
    status_t             status;
    logic                last;
  } list_beat_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [VALUE_W-1:0]    s_axis_tdata = '0;   // value[31:0]
  logic [FUNC_W-1:0]     s_axis_tuser = '0;   // func[1:0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // item_value[31:0], position[36:32],
                                              // count[41:37], zero[47:42]
  logic [STATUS_W-1:0]   m_axis_tuser;        // status[1:0]
  logic                  m_axis_tlast;

  logic signed [VALUE_W-1:0] list_vals [CAP];
  int                        held = 0;
  list_beat_t                expected_beats [$];
  int                        errors = 0;
  int                        quiet_cycles = 0;
  bit                        steady = 1'b0;

  sorted_list_insert_dedupe_core #(
    .CAPACITY(CAP)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk = ~clk;

  function automatic void push_beat(logic [VALUE_W-1:0] val, int pos, status_t st,
                                    logic lst);
    list_beat_t b;
    b.item_value = val;
    b.position   = pos[POS_W-1:0];
    b.count      = held[CNT_W-1:0];
    b.status     = st;
    b.last       = lst;
    expected_beats.push_back(b);
  endfunction

  function automatic void apply_list_op(func_t op, logic signed [VALUE_W-1:0] v);
    int at;
    int kept;
    case (op)
      FUNC_INSERT: begin
        if (held >= CAP) begin
          push_beat('0, 0, STATUS_FULL, 1'b1);
        end else begin
          at = 0;
          while (at < held && list_vals[at] < v) at++;
          for (int i = held; i > at; i--) list_vals[i] = list_vals[i-1];
          list_vals[at] = v;
          held++;
          push_beat('0, 0, STATUS_OK, 1'b1);
        end
      end
      FUNC_DEDUPE: begin
        kept = 0;
        for (int i = 0; i < held; i++) begin
          if (kept == 0 || list_vals[kept-1] != list_vals[i]) begin
            list_vals[kept] = list_vals[i];
            kept++;
          end
        end
        held = kept;
        push_beat('0, 0, STATUS_OK, 1'b1);
      end
      default: begin
        if (held == 0) begin
          push_beat('0, 0, STATUS_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < held; i++) begin
            push_beat(op == FUNC_READ_ASC ? list_vals[i] : list_vals[held-1-i], i,
                      STATUS_OK, i == held - 1);
          end
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : scoreboard
    list_beat_t want;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      apply_list_op(func_t'(s_axis_tuser), s_axis_tdata);
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("beat with nothing expected", 64'(m_axis_tdata), '0);
      end else begin
        want = expected_beats.pop_front();
        if (m_axis_tdata[VALUE_W-1:0] !== want.item_value)
          report_mismatch("item_value", 64'(m_axis_tdata[VALUE_W-1:0]),
                          64'(want.item_value));
        if (m_axis_tdata[POS_LO +: POS_W] !== want.position)
          report_mismatch("position", 64'(m_axis_tdata[POS_LO +: POS_W]),
                          64'(want.position));
        if (m_axis_tdata[CNT_LO +: CNT_W] !== want.count)
          report_mismatch("count", 64'(m_axis_tdata[CNT_LO +: CNT_W]), 64'(want.count));
        if (m_axis_tuser !== want.status)
          report_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
        if (m_axis_tlast !== want.last)
          report_mismatch("last", 64'(m_axis_tlast), 64'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIM) begin
      $display("[sorted_list_insert_dedupe_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_cmd(input func_t op, input logic [VALUE_W-1:0] v);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (expected_beats.size() != 0);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 8) - 4;
    if (r < 55) begin
      case ($urandom_range(0, 3))
        0: return 32'h7fff_ffff;
        1: return 32'h8000_0000;
        2: return 32'h7fff_fffe;
        default: return 32'h8000_0001;
      endcase
    end
    return $urandom;
  endfunction

  function automatic func_t pick_func();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return FUNC_INSERT;
    if (r < 57) return FUNC_DEDUPE;
    if (r < 79) return FUNC_READ_ASC;
    return FUNC_READ_DESC;
  endfunction

  task automatic test_empty_list();
    send_cmd(FUNC_READ_ASC, $urandom);
    send_cmd(FUNC_READ_DESC, $urandom);
    send_cmd(FUNC_DEDUPE, $urandom);
  endtask

  task automatic test_insert_order();
    send_cmd(FUNC_INSERT, 32'h7fff_ffff);
    send_cmd(FUNC_INSERT, 32'h8000_0000);
    send_cmd(FUNC_INSERT, 32'h0000_0000);
    send_cmd(FUNC_INSERT, 32'hffff_ffff);
    send_cmd(FUNC_INSERT, 32'h0000_0001);
    send_cmd(FUNC_INSERT, 32'h0000_0005);
    send_cmd(FUNC_INSERT, 32'h0000_0005);
    send_cmd(FUNC_READ_ASC, $urandom);
    send_cmd(FUNC_READ_DESC, $urandom);
  endtask

  // Fills the list with repeated values, overflows it, then squeezes it.
  task automatic test_full_list();
    int fill;
    s_axis_tvalid <= 1'b0;
    wait_drained();
    fill = CAP - held;
    for (int i = 0; i < fill; i++) send_cmd(FUNC_INSERT, (i % 3) - 1);
    send_cmd(FUNC_INSERT, 32'h0000_0002);
    send_cmd(FUNC_READ_ASC, $urandom);
    send_cmd(FUNC_DEDUPE, $urandom);
    send_cmd(FUNC_READ_DESC, $urandom);
  endtask

  task automatic test_random_back_to_back(input int n_items);
    steady = 1'b1;
    repeat (n_items) send_cmd(pick_func(), pick_value());
    steady = 1'b0;
  endtask

  task automatic test_random_with_stalls(input int n_items);
    repeat (n_items) send_cmd(pick_func(), pick_value());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_list();
    test_insert_order();
    test_full_list();
    test_random_back_to_back(50);
    test_random_with_stalls(95);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("[sorted_list_insert_dedupe_core] OK");
    end else begin
      $display("[sorted_list_insert_dedupe_core] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/slid_pkg.sv
rtl/core/slid_ram.sv
rtl/core/sorted_list_insert_dedupe_core.sv
test/tb_top.sv
